@@ design/spq_pkg.sv @@
// shared types and constants for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

  localparam int SPQ_DEPTH = 16;
  localparam int DATA_W    = 8;
  localparam int PRIO_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic              insert;
    logic              remove;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } spq_cmd_t;

endpackage

@@ design/sorted_priority_queue.sv @@
// sorted priority queue top level: chain of compare-and-shift cells
`timescale 1ns / 1ps
//
// usage
//   input word: in_command, in_item_data, in_item_priority, taken at a rising
//   edge where start is high and busy is low; busy stays low, so a word can be
//   issued in every cycle
//   in_command = insert places the entry behind all entries of lower or equal
//   priority value; remove pops the entry with the smallest priority value
//   result word: out_removed_data, out_removed_valid, out_status and
//   out_occupancy are shown for exactly one cycle with out_valid high, in the
//   cycle right after the command was taken
//   throughput: one command per cycle; every cell compares its priority with
//   the new one and shifts left or right in the same edge, so the chain
//   length does not set the rate
//   out_status: ok, full (insert dropped) or empty (remove with nothing held)
//   reset (rst_n low, synchronous) empties the queue; the slot contents are
//   left as they are and are never read before being written
//   the receiver cannot stall; a result not taken in its cycle is gone
//
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [spq_pkg::DATA_W-1:0]    in_item_data,
  input  logic [spq_pkg::PRIO_W-1:0]    in_item_priority,
  output logic                          out_valid,
  output logic [spq_pkg::DATA_W-1:0]    out_removed_data,
  output logic                          out_removed_valid,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [spq_pkg::OCC_W-1:0]     out_occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                accept;
  logic                is_full;
  logic                is_empty;
  spq_cmd_t            cmd;

  // entry count, the only control state of the store
  logic [CNT_W-1:0]    count_r, count_nxt;

  // registered result word
  logic                out_valid_r;
  logic [DATA_W-1:0]   rdata_r, rdata_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [OCC_W-1:0]    occ_out_r, occ_out_nxt;
  logic [OCC_W+CNT_W-1:0] count_ext;

  // cell taps
  logic                c_gt   [QUEUE_DEPTH];
  logic [DATA_W-1:0]   c_data [QUEUE_DEPTH];
  logic [PRIO_W-1:0]   c_prio [QUEUE_DEPTH];
  logic                c_occ  [QUEUE_DEPTH];

  // a new command is taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  // broadcast operation; dropped inserts and empty removes leave the chain alone
  always_comb begin
    cmd.insert = accept && (in_command == CMD_INSERT) && !is_full;
    cmd.remove = accept && (in_command == CMD_REMOVE) && !is_empty;
    cmd.data   = in_item_data;
    cmd.prio   = in_item_priority;
  end

  // the chain: slot 0 holds the head entry
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic              l_gt;
    logic [DATA_W-1:0] l_data;
    logic [PRIO_W-1:0] l_prio;
    logic [DATA_W-1:0] r_data;
    logic [PRIO_W-1:0] r_prio;

    assign c_occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign l_gt   = 1'b0;
      assign l_data = '0;
      assign l_prio = '0;
    end else begin : g_body
      assign l_gt   = c_gt[i-1];
      assign l_data = c_data[i-1];
      assign l_prio = c_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // the last slot is past the count after a remove, contents do not matter
      assign r_data = c_data[i];
      assign r_prio = c_prio[i];
    end else begin : g_inner
      assign r_data = c_data[i+1];
      assign r_prio = c_prio[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (c_occ[i]),
      .left_gt    (l_gt),
      .left_data  (l_data),
      .left_prio  (l_prio),
      .right_data (r_data),
      .right_prio (r_prio),
      .gt         (c_gt[i]),
      .data       (c_data[i]),
      .prio       (c_prio[i])
    );
  end

  // count and result word
  always_comb begin
    count_nxt  = count_r;
    rdata_nxt  = '0;
    rvalid_nxt = 1'b0;
    status_nxt = ST_OK;
    if (in_command == CMD_INSERT) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        rdata_nxt  = c_data[0];
        rvalid_nxt = 1'b1;
        count_nxt  = count_r - CNT_W'(1);
      end
    end
    // occupancy carries the low bits of the count
    count_ext   = {{OCC_W{1'b0}}, count_nxt};
    occ_out_nxt = count_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r   <= rdata_nxt;
      rvalid_r  <= rvalid_nxt;
      status_r  <= status_nxt;
      occ_out_r <= occ_out_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_data  = rdata_r;
  assign out_removed_valid = rvalid_r;
  assign out_status        = status_r;
  assign out_occupancy     = occ_out_r;

`ifndef SYNTHESIS
  // every accepted word gives exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  // count never runs past the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  // the two head slots stay in priority order
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (c_prio[0] <= c_prio[1]))
    else $error("head entries out of order");

  // a returned entry always comes with ok status
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_removed_valid) |-> (out_status == ST_OK))
    else $error("removed entry with bad status");
`endif

endmodule

@@ design/spq_cell.sv @@
// one slot of the sorted chain: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps

module spq_cell (
  input  logic                      clk,
  input  spq_pkg::spq_cmd_t         cmd,
  input  logic                      occ,
  input  logic                      left_gt,
  input  logic [spq_pkg::DATA_W-1:0] left_data,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [spq_pkg::DATA_W-1:0] right_data,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  output logic                      gt,
  output logic [spq_pkg::DATA_W-1:0] data,
  output logic [spq_pkg::PRIO_W-1:0] prio
);
  import spq_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;

  // occupied and ranked after the incoming entry
  assign gt = occ && (prio_r > cmd.prio);

  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (cmd.insert && !(occ && !gt)) begin
      if (left_gt) begin
        data_nxt = left_data;
        prio_nxt = left_prio;
      end else begin
        data_nxt = cmd.data;
        prio_nxt = cmd.prio;
      end
    end else if (cmd.remove) begin
      data_nxt = right_data;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule
